/* sv/dtl_pkg.sv */
// shared types and codes for the deadline timer list
// no dependencies
package dtl_pkg;

	localparam int STAMP_W = 16;

	typedef enum logic [1:0] {
		FN_START = 2'd0,
		FN_STOP  = 2'd1,
		FN_PROC  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_ARMED   = 2'd1,
		ST_EXPIRED = 2'd2
	} slot_status_t;

	typedef struct packed {
		logic        fired_valid;
		logic [4:0]  fired_timer;
		logic [31:0] wait_ticks;
		logic        is_last;
	} result_t;

endpackage

/* sv/deadline_timer_list.sv */
// Deadline timer list: one-shot timer slots on a wrapping tick clock, kept in a
// single-port-read slot memory that is scanned one slot per cycle. One operation
// is taken at a time. A stop reads its slot and writes it back idle; a start
// takes (k+1) scan passes and then arms the slot, where k slots expire in its
// check; a process takes (k+1)+(f+1)+1 passes, f being the slots it fires,
// plus any stall on the result side.
module deadline_timer_list #(
	parameter int TIMERS    = 32,
	parameter int TICK_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // timer_id[4:0], delay_ticks[36:5], now_tick[68:37]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // fired_timer[4:0], wait_ticks[36:5]
	output logic        m_tuser,   // fired_valid
	output logic        m_tlast    // is_last
);

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CW = $clog2(TIMERS + 1);
	localparam int SW = dtl_pkg::STAMP_W;
	localparam int DW = 2 + SW + TICK_BITS;
	localparam logic [TICK_BITS-1:0] LIMIT = {1'b0, {(TICK_BITS-1){1'b1}}};

	typedef enum logic [3:0] {
		S_IDLE, S_STOP_RD, S_STOP_WR, S_CHK, S_CHK_WR, S_ARM,
		S_FIRE, S_FIRE_EMIT, S_WAIT, S_WAIT_EMIT
	} state_t;

	state_t              state_q;
	dtl_pkg::func_t      func_q;
	logic [4:0]          id_q;
	logic [TICK_BITS-1:0] now_q, delay_q;
	logic [SW-1:0]       counter_q, cnt0_q;
	logic [CW-1:0]       cnt_q;
	logic                rd_vld_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic                found_q;
	logic [IW-1:0]       best_idx_q;
	logic [TICK_BITS-1:0] best_key_q, best_dl_q;
	logic [SW-1:0]       best_age_q;

	logic                 scanning, issue, scan_done, id_ok;
	logic                 re, we, out_rdy, push;
	logic [IW-1:0]        raddr, waddr;
	logic [DW-1:0]        wdata, rdata;
	dtl_pkg::slot_status_t rd_status;
	logic [SW-1:0]        rd_stamp, age_chk, age_fire, sel_age;
	logic [TICK_BITS-1:0] rd_dl, over, left, arm_dl, sel_key;
	logic                 arm_reach, cand, better;
	dtl_pkg::result_t     res;

	assign id_ok = 32'(s_tdata[4:0]) < 32'(TIMERS);

	assign rd_status = dtl_pkg::slot_status_t'(rdata[DW-1 -: 2]);
	assign rd_stamp  = rdata[TICK_BITS +: SW];
	assign rd_dl     = rdata[TICK_BITS-1:0];

	assign over     = now_q - rd_dl;
	assign left     = rd_dl - now_q;
	assign age_chk  = cnt0_q - rd_stamp;
	assign age_fire = counter_q - rd_stamp;
	assign arm_dl    = now_q + delay_q;
	assign arm_reach = (now_q - arm_dl) < LIMIT;

	assign scanning  = (state_q == S_CHK) || (state_q == S_FIRE) || (state_q == S_WAIT);
	assign issue     = scanning && (cnt_q != CW'(TIMERS));
	assign scan_done = scanning && !issue && !rd_vld_s1;

	// candidate test and ordering for the current pass
	always_comb begin
		cand    = 1'b0;
		better  = 1'b0;
		sel_key = over;
		sel_age = age_chk;
		case (state_q)
			S_CHK: begin
				cand   = (rd_status == dtl_pkg::ST_ARMED) && (over < LIMIT);
				better = !found_q || (over > best_key_q) ||
				         ((over == best_key_q) && (age_chk > best_age_q));
			end
			S_FIRE: begin
				sel_age = age_fire;
				cand    = rd_status == dtl_pkg::ST_EXPIRED;
				better  = !found_q || (age_fire > best_age_q);
			end
			S_WAIT: begin
				sel_key = left;
				cand    = rd_status == dtl_pkg::ST_ARMED;
				better  = !found_q || (left < best_key_q);
			end
			default: ;
		endcase
	end

	assign re    = issue || (state_q == S_STOP_RD);
	assign raddr = (state_q == S_STOP_RD) ? IW'(id_q) : cnt_q[IW-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = best_idx_q;
		wdata = {dtl_pkg::ST_IDLE, counter_q, best_dl_q};
		case (state_q)
			S_CHK_WR: begin
				we    = 1'b1;
				wdata = {dtl_pkg::ST_EXPIRED, counter_q, best_dl_q};
			end
			S_ARM: begin
				we    = 1'b1;
				waddr = IW'(id_q);
				wdata = {arm_reach ? dtl_pkg::ST_EXPIRED : dtl_pkg::ST_ARMED,
				         counter_q, arm_dl};
			end
			S_STOP_WR: begin
				we    = 1'b1;
				waddr = IW'(id_q);
				wdata = {dtl_pkg::ST_IDLE, rd_stamp, rd_dl};
			end
			S_FIRE_EMIT: we = out_rdy;
			default: ;
		endcase
	end

	assign push = out_rdy && ((state_q == S_FIRE_EMIT) || (state_q == S_WAIT_EMIT));

	always_comb begin
		res = '0;
		if (state_q == S_FIRE_EMIT) begin
			res.fired_valid = 1'b1;
			res.fired_timer = 5'(best_idx_q);
		end else begin
			res.wait_ticks = 32'(found_q ? best_key_q : {TICK_BITS{1'b1}});
			res.is_last    = 1'b1;
		end
	end

	assign s_tready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			counter_q <= '0;
			cnt0_q    <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			func_q    <= dtl_pkg::FN_START;
			id_q      <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rd_vld_s1 && cand && better) begin
				found_q    <= 1'b1;
				best_idx_q <= rd_idx_s1;
				best_key_q <= sel_key;
				best_age_q <= sel_age;
				best_dl_q  <= rd_dl;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						func_q  <= dtl_pkg::func_t'(s_tuser);
						id_q    <= s_tdata[4:0];
						delay_q <= TICK_BITS'(s_tdata[36:5]);
						now_q   <= TICK_BITS'(s_tdata[68:37]);
						cnt0_q  <= counter_q;
						cnt_q   <= '0;
						found_q <= 1'b0;
						case (s_tuser)
							dtl_pkg::FN_START: if (id_ok) state_q <= S_CHK;
							dtl_pkg::FN_STOP:  if (id_ok) state_q <= S_STOP_RD;
							dtl_pkg::FN_PROC:  state_q <= S_CHK;
							default: ;
						endcase
					end
				end
				S_STOP_RD: state_q <= S_STOP_WR;
				S_STOP_WR: state_q <= S_IDLE;
				S_CHK: begin
					if (scan_done) begin
						if (found_q) begin
							state_q <= S_CHK_WR;
						end else if (func_q == dtl_pkg::FN_START) begin
							state_q <= S_ARM;
						end else begin
							state_q <= S_FIRE;
							cnt_q   <= '0;
						end
					end
				end
				S_CHK_WR: begin
					counter_q <= counter_q + 1'b1;
					found_q   <= 1'b0;
					cnt_q     <= '0;
					state_q   <= S_CHK;
				end
				S_ARM: begin
					counter_q <= counter_q + 1'b1;
					state_q   <= S_IDLE;
				end
				S_FIRE: begin
					if (scan_done) begin
						if (found_q) begin
							state_q <= S_FIRE_EMIT;
						end else begin
							state_q <= S_WAIT;
							cnt_q   <= '0;
						end
					end
				end
				S_FIRE_EMIT: begin
					if (out_rdy) begin
						found_q <= 1'b0;
						cnt_q   <= '0;
						state_q <= S_FIRE;
					end
				end
				S_WAIT: if (scan_done) state_q <= S_WAIT_EMIT;
				S_WAIT_EMIT: if (out_rdy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IW-1:0];
	end

	dtl_slot_ram #(
		.DEPTH(TIMERS),
		.AW   (IW),
		.DW   (DW)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	dtl_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.res     (res),
		.rdy     (out_rdy),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

/* sv/dtl_slot_ram.sv */
// slot table: synchronous memory, one write and one read port, registered read
// invalid (never written) entries read as zero, which is the idle status
// uses no package
module dtl_slot_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [DW-1:0]    rdata_q;
	logic             rd_written_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_written_q <= written_q[raddr];
			end
		end
	end

	assign rdata = rd_written_q ? rdata_q : '0;

endmodule

/* sv/dtl_out_reg.sv */
// output register for result transactions
// depends on dtl_pkg
module dtl_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dtl_pkg::result_t res,
	output logic             rdy,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	logic             vld_q;
	dtl_pkg::result_t res_q;

	assign rdy = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rdy) begin
			vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && push) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {3'b000, res_q.wait_ticks, res_q.fired_timer};
	assign m_tuser  = res_q.fired_valid;
	assign m_tlast  = res_q.is_last;

endmodule
